### rtl/pcr_pkg.sv
// Package for the piecewise color ramp: sizes, shared types and the
// divide-by-100 helper used to split decimal-packed colors.
// No dependencies.
`default_nettype none
package pcr_pkg;

  localparam int POINTS     = 4;
  localparam int VALUE_BITS = 16;
  localparam int REG_POINTS = 4;
  localparam int COLOR_W    = 20;
  localparam int LEVEL_W    = 7;
  localparam int CHANNELS   = 3;
  localparam int Q1_W       = 14;

  localparam int DIFF_W     = VALUE_BITS + 1;
  localparam int NUM_W      = VALUE_BITS + LEVEL_W + 1;
  localparam int PT_W       = $clog2(POINTS);
  localparam int RP_W       = $clog2(REG_POINTS);
  localparam int CFG_AW     = RP_W + 1;
  localparam int DIV_STEPS  = LEVEL_W;
  localparam int IN_W       = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_FLD_W  = COLOR_W + CHANNELS * LEVEL_W + 1;
  localparam int OUT_W      = ((OUT_FLD_W + 7) / 8) * 8;

  localparam int LEVEL_MAX  = 99;
  localparam int RED_WEIGHT = 10000;
  localparam int GRN_WEIGHT = 100;
  localparam int RECIP_100  = 5243;   // ceil(2^19 / 100)
  localparam int RECIP_SH   = 19;
  localparam int PROD_W     = COLOR_W + 14;

  // channel index: 2 red, 1 green, 0 blue
  localparam int CH_RED = 2;
  localparam int CH_GRN = 1;
  localparam int CH_BLU = 0;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [CHANNELS-1:0][LEVEL_W-1:0] chans_t;

  typedef struct packed {
    logic [CHANNELS-1:0][NUM_W-1:0]   rem;
    logic [CHANNELS-1:0][LEVEL_W-1:0] quo;
    logic [NUM_W-1:0]                 dvs;
    logic                             in_seg;
  } div_t;

  // n / 100 for n < 2^20: reciprocal estimate is high by at most one
  function automatic logic [Q1_W-1:0] div100(input logic [COLOR_W-1:0] n);
    logic [PROD_W-1:0]  prod;
    logic [Q1_W-1:0]    q;
    logic [PROD_W-1:0]  back;
    prod = PROD_W'(n) * PROD_W'(RECIP_100);
    q    = Q1_W'(prod >> RECIP_SH);
    back = PROD_W'(q) * PROD_W'(GRN_WEIGHT);
    if (back > PROD_W'(n)) begin
      q = q - 1'b1;
    end
    return q;
  endfunction

endpackage
`default_nettype wire

### rtl/piecewise_color_ramp.sv
// Piecewise color ramp top: breakpoint registers, segment select, blend
// products, a chain of pcr_cell dividers and the output register.
// Depends on pcr_pkg, pcr_split and pcr_cell.
`default_nettype none
// Takes one scalar item per cycle while out_tready is held high and
// returns one color item per item. Each item passes through three front
// stages (segment select, distances, blend products), seven divider
// cells (one quotient bit each) and the output register.
// Each stage stalls only when the one after it is full, so bubbles are
// squeezed out under backpressure. Color registers pass through a two-stage
// splitter into channels, so a configuration write is in effect for any
// item accepted on a later cycle.
module piecewise_color_ramp
  import pcr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [IN_W-1:0]     in_tdata,   // [15:0] scalar_value
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OUT_W-1:0]         out_tdata,  // [19:0] color_code, [26:20] red_level,
                                               // [33:27] green_level, [40:34] blue_level,
                                               // [41] inside_range
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_AW-1:0]   cfg_addr,
  input  wire logic [COLOR_W-1:0]  cfg_wr_data
);

  logic signed [VALUE_BITS-1:0] pos_r [REG_POINTS];
  logic [COLOR_W-1:0]           col_r [REG_POINTS];
  chans_t                       chans [REG_POINTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_POINTS; i++) begin
        pos_r[i] <= '0;
        col_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_addr[CFG_AW-1]) begin
        col_r[cfg_addr[RP_W-1:0]] <= cfg_wr_data;
      end else begin
        pos_r[cfg_addr[RP_W-1:0]] <= cfg_wr_data[VALUE_BITS-1:0];
      end
    end
  end

  for (genvar g = 0; g < REG_POINTS; g++) begin : g_split
    pcr_split u_split (
      .clk   (clk),
      .rst_n (rst_n),
      .code  (col_r[g]),
      .chans (chans[g])
    );
  end

  // ---- stage 1: segment select
  logic signed [VALUE_BITS-1:0] x_in;
  logic                         hit;
  logic [PT_W-1:0]              seg;
  logic                         s1_v_r, s1_in_r, s1_rdy;
  logic signed [VALUE_BITS-1:0] s1_x_r;
  logic [PT_W-1:0]              s1_k_r;

  assign x_in = in_tdata[VALUE_BITS-1:0];

  always_comb begin
    hit = 1'b0;
    seg = '0;
    // scan downward so the lowest-numbered matching segment wins
    for (int i = POINTS - 2; i >= 0; i--) begin
      if (x_in >= pos_r[i] && x_in <= pos_r[i+1]) begin
        hit = 1'b1;
        seg = PT_W'(i);
      end
    end
  end

  // ---- stage 2: distances to the segment ends
  logic                         s2_v_r, s2_in_r, s2_rdy;
  logic [DIFF_W-1:0]            s2_a_r, s2_b_r, s2_span_r;
  logic [PT_W-1:0]              s2_k_r;
  logic signed [VALUE_BITS-1:0] lo, hi;
  logic [PT_W-1:0]              k_up1;

  always_comb begin
    k_up1 = s1_k_r + 1'b1;
    lo    = pos_r[s1_k_r];
    hi    = pos_r[k_up1];
  end

  // ---- stage 3: blend numerators
  div_t              div_in;
  logic [PT_W-1:0]   k2_up1;
  chans_t            c_lo, c_hi;
  logic              s3_v_r, s3_rdy;
  div_t              s3_d_r;

  always_comb begin
    k2_up1 = s2_k_r + 1'b1;
    c_lo   = chans[s2_k_r];
    c_hi   = chans[k2_up1];
    div_in = '0;
    div_in.in_seg = s2_in_r;
    if (s2_span_r == '0) begin
      // zero-length segment: divide start color by one
      for (int c = 0; c < CHANNELS; c++) begin
        div_in.rem[c] = NUM_W'(c_lo[c]);
      end
      div_in.dvs = NUM_W'(1) << (DIV_STEPS - 1);
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        div_in.rem[c] = NUM_W'(c_lo[c]) * NUM_W'(s2_a_r)
                      + NUM_W'(c_hi[c]) * NUM_W'(s2_b_r);
      end
      div_in.dvs = NUM_W'(s2_span_r) << (DIV_STEPS - 1);
    end
  end

  // ---- divider chain
  logic cv   [DIV_STEPS+1];
  logic crdy [DIV_STEPS+1];
  div_t cd   [DIV_STEPS+1];
  logic out_rdy;

  assign cv[0] = s3_v_r;
  assign cd[0] = s3_d_r;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    pcr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[g]),
      .in_ready  (crdy[g]),
      .in_data   (cd[g]),
      .out_valid (cv[g+1]),
      .out_ready (crdy[g+1]),
      .out_data  (cd[g+1])
    );
  end

  assign crdy[DIV_STEPS] = out_rdy;

  // ---- ready chain
  assign out_rdy   = !out_tvalid || out_tready;
  assign s3_rdy    = !s3_v_r || crdy[0];
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_tvalid) begin
      s1_x_r  <= x_in;
      s1_k_r  <= seg;
      s1_in_r <= hit;
    end
    if (s2_rdy && s1_v_r) begin
      s2_a_r    <= {hi[VALUE_BITS-1], hi} - {s1_x_r[VALUE_BITS-1], s1_x_r};
      s2_b_r    <= {s1_x_r[VALUE_BITS-1], s1_x_r} - {lo[VALUE_BITS-1], lo};
      s2_span_r <= {hi[VALUE_BITS-1], hi} - {lo[VALUE_BITS-1], lo};
      s2_k_r    <= s1_k_r;
      s2_in_r   <= s1_in_r;
    end
    if (s3_rdy && s2_v_r) begin
      s3_d_r <= div_in;
    end
  end

  // ---- output stage
  div_t               fin;
  chans_t             lvl;
  logic [COLOR_W-1:0] code;
  logic               out_v_r;
  logic [OUT_W-1:0]   out_d_r, out_d_nxt;

  always_comb begin
    fin = cd[DIV_STEPS];
    lvl = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (!fin.in_seg) begin
        lvl[c] = '0;
      end else if (fin.quo[c] > LEVEL_W'(LEVEL_MAX)) begin
        lvl[c] = LEVEL_W'(LEVEL_MAX);
      end else begin
        lvl[c] = fin.quo[c];
      end
    end
    code = COLOR_W'(lvl[CH_RED]) * COLOR_W'(RED_WEIGHT)
         + COLOR_W'(lvl[CH_GRN]) * COLOR_W'(GRN_WEIGHT)
         + COLOR_W'(lvl[CH_BLU]);
    out_d_nxt = OUT_W'({fin.in_seg, lvl[CH_BLU], lvl[CH_GRN], lvl[CH_RED], code});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= cv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && cv[DIV_STEPS]) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // ---- checks
  localparam int RED_LO = COLOR_W;
  localparam int GRN_LO = COLOR_W + LEVEL_W;
  localparam int BLU_LO = COLOR_W + 2 * LEVEL_W;
  localparam int INS_B  = COLOR_W + 3 * LEVEL_W;

  a_levels_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[RED_LO +: LEVEL_W] <= LEVEL_W'(LEVEL_MAX))
                && (out_tdata[GRN_LO +: LEVEL_W] <= LEVEL_W'(LEVEL_MAX))
                && (out_tdata[BLU_LO +: LEVEL_W] <= LEVEL_W'(LEVEL_MAX)))
    else $error("channel level above 99");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[INS_B]) |-> (out_tdata[INS_B-1:0] == '0))
    else $error("outside item carries nonzero color");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready && s1_v_r && s2_v_r && s3_v_r))
    else $error("input stalled while pipeline has room");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

### rtl/pcr_split.sv
// Splits one decimal-packed RRGGBB color register into three channels
// over two register stages. Depends on pcr_pkg.
`default_nettype none
module pcr_split
  import pcr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [COLOR_W-1:0] code,
  output chans_t                  chans
);

  logic [Q1_W-1:0] q1_r, q1_nxt;
  level_t          blu_a_r, blu_a_nxt;
  chans_t          chans_r, chans_nxt;
  logic [Q1_W-1:0] q2;

  always_comb begin
    q1_nxt    = div100(code);
    blu_a_nxt = LEVEL_W'(code - COLOR_W'(q1_nxt) * COLOR_W'(GRN_WEIGHT));
    q2        = div100(COLOR_W'(q1_r));
    chans_nxt = '0;
    chans_nxt[CH_RED] = (q2 >= Q1_W'(GRN_WEIGHT)) ? LEVEL_W'(q2 - Q1_W'(GRN_WEIGHT))
                                                   : LEVEL_W'(q2);
    chans_nxt[CH_GRN] = LEVEL_W'(q1_r - Q1_W'(q2 * Q1_W'(GRN_WEIGHT)));
    chans_nxt[CH_BLU] = blu_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_r    <= '0;
      blu_a_r <= '0;
      chans_r <= '0;
    end else begin
      q1_r    <= q1_nxt;
      blu_a_r <= blu_a_nxt;
      chans_r <= chans_nxt;
    end
  end

  assign chans = chans_r;

endmodule
`default_nettype wire

### rtl/pcr_cell.sv
// One restoring-division cell: settles one quotient bit for all three
// channels and hands the halved divisor on. Depends on pcr_pkg.
`default_nettype none
module pcr_cell
  import pcr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire div_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output div_t      out_data
);

  logic v_r;
  div_t d_r, d_nxt;

  always_comb begin
    d_nxt = in_data;
    for (int c = 0; c < CHANNELS; c++) begin
      if (in_data.rem[c] >= in_data.dvs) begin
        d_nxt.rem[c] = in_data.rem[c] - in_data.dvs;
        d_nxt.quo[c] = {in_data.quo[c][LEVEL_W-2:0], 1'b1};
      end else begin
        d_nxt.quo[c] = {in_data.quo[c][LEVEL_W-2:0], 1'b0};
      end
    end
    d_nxt.dvs = in_data.dvs >> 1;
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule
`default_nettype wire
